### hw/rtl/tel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tel_pkg
// Shared word types, command codes and widths for the tabu edge list.
// ----------------------------------------------------------------------------
package tel_pkg;

	localparam int NODE_W = 10;
	localparam int TEN_W  = 8;
	localparam int OCC_W  = 7;

	localparam logic [1:0] KIND_QUERY  = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	localparam logic [TEN_W-1:0] TENURE_RESET = 8'd8;

	typedef struct packed {
		logic [1:0]        kind;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} cmd_t;

	typedef struct packed {
		logic             is_tabu;
		logic             inserted;
		logic             overflow;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	// token that walks the cell row
	typedef struct packed {
		logic              active;
		logic [1:0]        kind;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic              hit;
		logic              free_found;
	} token_t;

	// broadcast write of a new entry
	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [TEN_W-1:0]  remaining;
	} wr_t;

endpackage
`default_nettype wire

### hw/rtl/tel_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tel_cell
// One table entry: compares, ages and counts as the token passes through.
// ----------------------------------------------------------------------------
module tel_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  tel_pkg::token_t       tok_in,
	input  wire  [IDX_W-1:0]      idx_in,
	input  wire  [CNT_W-1:0]      cnt_in,
	input  tel_pkg::wr_t          wr,
	input  wire  [IDX_W-1:0]      wr_idx,
	output tel_pkg::token_t       tok_out,
	output logic [IDX_W-1:0]      idx_out,
	output logic [CNT_W-1:0]      cnt_out
);

	logic                          valid_q;
	logic [tel_pkg::NODE_W-1:0]    first_q;
	logic [tel_pkg::NODE_W-1:0]    second_q;
	logic [tel_pkg::TEN_W-1:0]     rem_q;

	tel_pkg::token_t               tok_nx;
	logic [IDX_W-1:0]              idx_nx;
	logic [CNT_W-1:0]              cnt_nx;
	logic                          match;
	logic                          is_tick;
	logic                          expire;
	logic                          wr_here;

	assign is_tick = (tok_in.kind == tel_pkg::KIND_TICK);
	assign match   = valid_q &&
		((first_q == tok_in.node_a && second_q == tok_in.node_b) ||
		 (first_q == tok_in.node_b && second_q == tok_in.node_a));
	assign expire  = tok_in.active && is_tick && valid_q &&
		(rem_q <= tel_pkg::TEN_W'(1));
	assign wr_here = wr.en && (wr_idx == IDX_W'(INDEX));

	always_comb begin
		tok_nx = tok_in;
		idx_nx = idx_in;
		cnt_nx = cnt_in;
		if (is_tick) begin
			if (valid_q && rem_q > tel_pkg::TEN_W'(1))
				cnt_nx = cnt_in + CNT_W'(1);
		end else begin
			if (match)
				tok_nx.hit = 1'b1;
			if (valid_q) begin
				cnt_nx = cnt_in + CNT_W'(1);
			end else if (!tok_in.free_found) begin
				tok_nx.free_found = 1'b1;
				idx_nx = IDX_W'(INDEX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_out <= '0;
		end else begin
			tok_out <= tok_nx;
			if (wr_here)
				valid_q <= 1'b1;
			else if (expire)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_out <= idx_nx;
		cnt_out <= cnt_nx;
		if (wr_here) begin
			first_q  <= wr.node_a;
			second_q <= wr.node_b;
			rem_q    <= wr.remaining;
		end else if (tok_in.active && is_tick && valid_q) begin
			rem_q <= rem_q - tel_pkg::TEN_W'(1);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tabu_edge_list_with_tenure.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tabu_edge_list_with_tenure
// Table of undirected edges with tenure aging, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command word on cmd is taken at a clock edge where start is high and busy
//   is low. kind selects query, insert or tick; a kind of 3 acts as a query.
//   One result word per command appears on result for exactly one cycle,
//   marked by done; the receiver cannot hold it off.
//   tenure_we / tenure_wdata write the tenure register (reset value 8; a
//   value of 0 acts as 1). Write it only while busy is low.
// Timing:
//   The command token walks the row of DEPTH cells, one cell per cycle,
//   collecting hit, lowest free slot and live count. done is registered
//   from the last cell's output, and busy falls at the same edge, so a new
//   command is taken only once the last one is done. An insert writes its
//   slot in the cycle done is high, before the next command reaches the row.
// Reset:
//   arst_n clears every entry's valid bit, the token row and busy; the table
//   starts empty and the block takes a command right after reset.
// ----------------------------------------------------------------------------
module tabu_edge_list_with_tenure #(
	parameter int DEPTH = 64
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  tel_pkg::cmd_t               cmd,
	output logic                        done,
	output tel_pkg::result_t            result,
	input  wire                         tenure_we,
	input  wire  [tel_pkg::TEN_W-1:0]   tenure_wdata
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tel_pkg::token_t              chain_tok [DEPTH+1];
	logic [IDX_W-1:0]             chain_idx [DEPTH+1];
	logic [CNT_W-1:0]             chain_cnt [DEPTH+1];

	tel_pkg::token_t              head_q;
	logic                         busy_q;
	logic                         done_q;
	tel_pkg::result_t             result_q;
	tel_pkg::wr_t                 wr_q;
	logic [IDX_W-1:0]             wr_idx_q;
	logic [tel_pkg::TEN_W-1:0]    tenure_q;

	tel_pkg::token_t              tail;
	logic                         accept;
	logic                         tail_insert;
	logic                         do_ins;
	logic                         do_ovf;
	logic [tel_pkg::TEN_W-1:0]    ten_eff;

	assign accept       = start && !busy_q;
	assign chain_tok[0] = head_q;
	assign chain_idx[0] = '0;
	assign chain_cnt[0] = '0;
	assign tail         = chain_tok[DEPTH];
	assign tail_insert  = (tail.kind == tel_pkg::KIND_INSERT) && !tail.hit;
	assign do_ins       = tail_insert && tail.free_found;
	assign do_ovf       = tail_insert && !tail.free_found;
	assign ten_eff      = (tenure_q == '0) ? tel_pkg::TEN_W'(1) : tenure_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		tel_cell #(
			.INDEX (g),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain_tok[g]),
			.idx_in  (chain_idx[g]),
			.cnt_in  (chain_cnt[g]),
			.wr      (wr_q),
			.wr_idx  (wr_idx_q),
			.tok_out (chain_tok[g+1]),
			.idx_out (chain_idx[g+1]),
			.cnt_out (chain_cnt[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			wr_q     <= '0;
			tenure_q <= tel_pkg::TENURE_RESET;
		end else begin
			head_q.active <= accept;
			if (accept) begin
				head_q.kind       <= cmd.kind;
				head_q.node_a     <= cmd.node_a;
				head_q.node_b     <= cmd.node_b;
				head_q.hit        <= 1'b0;
				head_q.free_found <= 1'b0;
			end
			if (accept)
				busy_q <= 1'b1;
			else if (tail.active)
				busy_q <= 1'b0;
			done_q    <= tail.active;
			wr_q.en   <= tail.active && do_ins;
			if (tenure_we)
				tenure_q <= tenure_wdata;
			if (tail.active) begin
				wr_q.node_a    <= tail.node_a;
				wr_q.node_b    <= tail.node_b;
				wr_q.remaining <= ten_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.active) begin
			wr_idx_q           <= chain_idx[DEPTH];
			result_q.is_tabu   <= (tail.kind != tel_pkg::KIND_TICK) && tail.hit;
			result_q.inserted  <= do_ins;
			result_q.overflow  <= do_ovf;
			result_q.occupancy <= tel_pkg::OCC_W'(chain_cnt[DEPTH] + CNT_W'(do_ins));
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	a_tok_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> busy_q)
		else $error("token in cell row while idle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("result word without a command in flight");

	a_ins_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(result_q.inserted && result_q.overflow))
		else $error("insert both stored and dropped");

	a_ins_absent: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.inserted |-> !result_q.is_tabu && wr_q.en)
		else $error("insert of present edge or missing slot write");

endmodule
`default_nettype wire
